/* rtl/rgsf_pkg.sv */
// Shared types and constants for the region gray/sepia pixel filter.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package rgsf_pkg;

	localparam int unsigned COORD_W = 12;
	localparam int unsigned CHAN_W  = 8;
	localparam int unsigned CFG_W   = 12;
	localparam int unsigned IDX_W   = 3;

	// Positions at or beyond this side length are never inside the region.
	localparam int unsigned MAX_SIDE = 4096;

	// Sepia matrix in thousandths; rows are output red, green, blue.
	localparam int unsigned SEPIA_K [3][3] = '{
		'{393, 769, 189},
		'{349, 686, 168},
		'{272, 534, 131}
	};
	localparam int unsigned SEPIA_ROUND = 500;

	// Exact division by 1000 for sums below 2^19, and by 3 for sums below 2^10.
	localparam int unsigned DOT_W      = 19;
	localparam int unsigned RECIP_W    = 20;
	localparam int unsigned PROD_W     = DOT_W + RECIP_W;
	localparam int unsigned DIV_SHIFT  = 29;
	localparam int unsigned RECIP_1000 = 536871;
	localparam int unsigned Q_W        = 9;

	localparam int unsigned GSUM_W     = 10;
	localparam int unsigned GRECIP_W   = 11;
	localparam int unsigned GPROD_W    = GSUM_W + GRECIP_W;
	localparam int unsigned GRAY_SHIFT = 12;
	localparam int unsigned RECIP_3    = 1366;

	typedef logic [CHAN_W-1:0]  chan_t;
	typedef logic [COORD_W-1:0] coord_t;

	typedef enum logic [IDX_W-1:0] {
		REG_FILTER_MODE  = 3'd0,
		REG_LEFT_COLUMN  = 3'd1,
		REG_TOP_ROW      = 3'd2,
		REG_RIGHT_COLUMN = 3'd3,
		REG_BOTTOM_ROW   = 3'd4,
		REG_MAX_LEVEL    = 3'd5
	} reg_index_t;

	typedef enum logic {
		MODE_GRAY  = 1'b0,
		MODE_SEPIA = 1'b1
	} filter_mode_t;

	typedef struct packed {
		filter_mode_t filter_mode;
		coord_t       left_column;
		coord_t       top_row;
		coord_t       right_column;
		coord_t       bottom_row;
		chan_t        max_level;
	} cfg_t;

	typedef struct packed {
		coord_t pixel_row;
		coord_t pixel_column;
		chan_t  red_in;
		chan_t  green_in;
		chan_t  blue_in;
	} pixel_in_t;

	typedef struct packed {
		chan_t red_out;
		chan_t green_out;
		chan_t blue_out;
	} pixel_out_t;

	// Channel index 0 is red, 1 green, 2 blue.
	typedef struct packed {
		chan_t [2:0]             rgb;
		logic                    in_region;
		logic [2:0][DOT_W-1:0]   dot;
		logic [GSUM_W-1:0]       gray_sum;
	} front_t;

	typedef struct packed {
		chan_t [2:0]             rgb;
		logic                    in_region;
		logic [2:0][Q_W-1:0]     sepia_q;
		chan_t                   gray_avg;
	} mid_t;

endpackage

`default_nettype wire

/* rtl/region_gray_sepia_filter.sv */
// Region gray/sepia pixel filter, top level with configuration registers.
// Accepts and delivers one beat per cycle while the output is not stalled.
// Each of the three stages advances when it is empty or its successor advances,
// so bubbles are squeezed out while the output is stalled.
// Reset clears all stage valid bits and loads the register defaults.
// Depends on rgsf_pkg, rgsf_front, rgsf_scale and rgsf_back.
`default_nettype none

module region_gray_sepia_filter
	import rgsf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  pixel_in_t              in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output pixel_out_t             out_data,
	input  wire logic              cfg_write,
	input  wire logic [IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_data
);

	cfg_t   cfg_q;
	logic   en1;
	logic   en2;
	logic   en3;
	logic   valid_s1;
	logic   valid_s2;
	front_t data_s1;
	mid_t   data_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.filter_mode  <= MODE_GRAY;
			cfg_q.left_column  <= '0;
			cfg_q.top_row      <= '0;
			cfg_q.right_column <= '1;
			cfg_q.bottom_row   <= '1;
			cfg_q.max_level    <= '1;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_FILTER_MODE:  cfg_q.filter_mode  <= filter_mode_t'(cfg_data[0]);
				REG_LEFT_COLUMN:  cfg_q.left_column  <= cfg_data[COORD_W-1:0];
				REG_TOP_ROW:      cfg_q.top_row      <= cfg_data[COORD_W-1:0];
				REG_RIGHT_COLUMN: cfg_q.right_column <= cfg_data[COORD_W-1:0];
				REG_BOTTOM_ROW:   cfg_q.bottom_row   <= cfg_data[COORD_W-1:0];
				REG_MAX_LEVEL:    cfg_q.max_level    <= cfg_data[CHAN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign en3      = !out_valid || out_ready;
	assign en2      = !valid_s2 || en3;
	assign en1      = !valid_s1 || en2;
	assign in_ready = en1;

	rgsf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en1),
		.valid    (in_valid),
		.pixel    (in_data),
		.cfg      (cfg_q),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	rgsf_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en2),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2)
	);

	rgsf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en3),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2),
		.cfg      (cfg_q),
		.valid_s3 (out_valid),
		.data_s3  (out_data)
	);

endmodule

`default_nettype wire

/* rtl/rgsf_front.sv */
// First pipeline stage: region test, sepia dot products and gray channel sum.
// Depends on rgsf_pkg.
`default_nettype none

module rgsf_front
	import rgsf_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      en,
	input  wire logic      valid,
	input  pixel_in_t      pixel,
	input  cfg_t           cfg,
	output logic           valid_s1,
	output front_t         data_s1
);

	front_t nxt;
	logic   row_ok;
	logic   col_ok;

	always_comb begin
		row_ok = (32'(pixel.pixel_row) < MAX_SIDE) &&
			(pixel.pixel_row >= cfg.top_row) && (pixel.pixel_row <= cfg.bottom_row);
		col_ok = (32'(pixel.pixel_column) < MAX_SIDE) &&
			(pixel.pixel_column >= cfg.left_column) &&
			(pixel.pixel_column <= cfg.right_column);
		nxt.in_region = row_ok && col_ok;
		nxt.rgb[0] = pixel.red_in;
		nxt.rgb[1] = pixel.green_in;
		nxt.rgb[2] = pixel.blue_in;
		for (int c = 0; c < 3; c++) begin
			nxt.dot[c] = DOT_W'(SEPIA_K[c][0]) * DOT_W'(pixel.red_in) +
				DOT_W'(SEPIA_K[c][1]) * DOT_W'(pixel.green_in) +
				DOT_W'(SEPIA_K[c][2]) * DOT_W'(pixel.blue_in) +
				DOT_W'(SEPIA_ROUND);
		end
		nxt.gray_sum = GSUM_W'(pixel.red_in) + GSUM_W'(pixel.green_in) +
			GSUM_W'(pixel.blue_in);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid) begin
			data_s1 <= nxt;
		end
	end

endmodule

`default_nettype wire

/* rtl/rgsf_scale.sv */
// Second pipeline stage: divides the sepia sums by 1000 and the gray sum by 3
// through reciprocal multiplication. Depends on rgsf_pkg.
`default_nettype none

module rgsf_scale
	import rgsf_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic valid_s1,
	input  front_t    data_s1,
	output logic      valid_s2,
	output mid_t      data_s2
);

	mid_t                    nxt;
	logic [2:0][PROD_W-1:0]  prod;
	logic [GPROD_W-1:0]      gprod;

	always_comb begin
		nxt.rgb       = data_s1.rgb;
		nxt.in_region = data_s1.in_region;
		for (int c = 0; c < 3; c++) begin
			prod[c] = PROD_W'(data_s1.dot[c]) * PROD_W'(RECIP_1000);
			nxt.sepia_q[c] = prod[c][DIV_SHIFT +: Q_W];
		end
		gprod = GPROD_W'(data_s1.gray_sum) * GPROD_W'(RECIP_3);
		nxt.gray_avg = gprod[GRAY_SHIFT +: CHAN_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s1) begin
			data_s2 <= nxt;
		end
	end

endmodule

`default_nettype wire

/* rtl/rgsf_back.sv */
// Third pipeline stage: sepia saturation, mode and region selection, and the
// output register. Depends on rgsf_pkg.
`default_nettype none

module rgsf_back
	import rgsf_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic valid_s2,
	input  mid_t      data_s2,
	input  cfg_t      cfg,
	output logic      valid_s3,
	output pixel_out_t data_s3
);

	chan_t [2:0] sat;
	chan_t [2:0] sel;
	pixel_out_t  nxt;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sat[c] = (data_s2.sepia_q[c] > Q_W'(cfg.max_level)) ? cfg.max_level
				: data_s2.sepia_q[c][CHAN_W-1:0];
			if (!data_s2.in_region) begin
				sel[c] = data_s2.rgb[c];
			end else if (cfg.filter_mode == MODE_GRAY) begin
				sel[c] = data_s2.gray_avg;
			end else begin
				sel[c] = sat[c];
			end
		end
		nxt.red_out   = sel[0];
		nxt.green_out = sel[1];
		nxt.blue_out  = sel[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s2) begin
			data_s3 <= nxt;
		end
	end

endmodule

`default_nettype wire

/* rtl/rgsf_checker.sv */
// Port-level checks for the region gray/sepia filter, bound to the top level.
// Depends on rgsf_pkg and region_gray_sepia_filter.
`default_nettype none

module rgsf_checker
	import rgsf_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input pixel_out_t             out_data
);

	logic [2:0] inflight_q;
	logic       in_beat;
	logic       out_beat;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_beat && !out_beat) begin
			inflight_q <= inflight_q + 3'd1;
		end else if (out_beat && !in_beat) begin
			inflight_q <= inflight_q - 3'd1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while output register is empty");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 3'd3)
		else $error("more beats in flight than pipeline stages");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == 3'd0 |-> !out_valid)
		else $error("output beat without a matching input beat");

endmodule

bind region_gray_sepia_filter rgsf_checker u_rgsf_checker (.*);

`default_nettype wire

/* bench/tb_region_gray_sepia_filter.sv */
// Self-checking testbench for the region gray/sepia pixel filter.
// A scoreboard predicts each output pixel from the accepted input and the register settings.
// Depends on rgsf_pkg and region_gray_sepia_filter.
`timescale 1ns / 1ps

module tb_region_gray_sepia_filter;
	import rgsf_pkg::*;

	localparam logic [IDX_W-1:0] REG_UNUSED_LO = 3'd6;
	localparam logic [IDX_W-1:0] REG_UNUSED_HI = 3'd7;

	class filter_scoreboard;
		cfg_t settings;
		pixel_out_t expected_pixels[$];
		int unsigned mismatches;

		function new();
			settings.filter_mode = MODE_GRAY;
			settings.left_column = '0;
			settings.top_row = '0;
			settings.right_column = 12'hFFF;
			settings.bottom_row = 12'hFFF;
			settings.max_level = 8'hFF;
			mismatches = 0;
		endfunction

		function void write_register(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
			case (idx)
				REG_FILTER_MODE: settings.filter_mode = filter_mode_t'(value[0]);
				REG_LEFT_COLUMN: settings.left_column = value;
				REG_TOP_ROW: settings.top_row = value;
				REG_RIGHT_COLUMN: settings.right_column = value;
				REG_BOTTOM_ROW: settings.bottom_row = value;
				REG_MAX_LEVEL: settings.max_level = value[7:0];
				default: ;
			endcase
		endfunction

		function chan_t sepia_level(int unsigned r, int unsigned g, int unsigned b,
				int unsigned kr, int unsigned kg, int unsigned kb);
			int unsigned v;
			v = (kr * r + kg * g + kb * b + 500) / 1000;
			if (v > settings.max_level)
				v = settings.max_level;
			return v[7:0];
		endfunction

		function pixel_out_t filter_pixel(pixel_in_t px);
			pixel_out_t res;
			int unsigned r, g, b, mean;
			logic in_region;
			r = px.red_in;
			g = px.green_in;
			b = px.blue_in;
			in_region = px.pixel_column >= settings.left_column &&
				px.pixel_column <= settings.right_column &&
				px.pixel_row >= settings.top_row && px.pixel_row <= settings.bottom_row;
			if (!in_region) begin
				res.red_out = px.red_in;
				res.green_out = px.green_in;
				res.blue_out = px.blue_in;
			end else if (settings.filter_mode == MODE_GRAY) begin
				mean = (r + g + b) / 3;
				res.red_out = mean[7:0];
				res.green_out = mean[7:0];
				res.blue_out = mean[7:0];
			end else begin
				res.red_out = sepia_level(r, g, b, 393, 769, 189);
				res.green_out = sepia_level(r, g, b, 349, 686, 168);
				res.blue_out = sepia_level(r, g, b, 272, 534, 131);
			end
			return res;
		endfunction

		function void note_pixel(pixel_in_t px);
			expected_pixels.push_back(filter_pixel(px));
		endfunction

		task report_mismatch(string line);
			$display("%0t ns: %s", $realtime, line);
			mismatches++;
		endtask

		task check_pixel(pixel_out_t got);
			pixel_out_t want;
			if (expected_pixels.size() == 0) begin
				report_mismatch($sformatf("output beat %h with nothing expected", got));
				return;
			end
			want = expected_pixels.pop_front();
			if (got.red_out !== want.red_out)
				report_mismatch($sformatf("red_out %0d, expected %0d",
					got.red_out, want.red_out));
			if (got.green_out !== want.green_out)
				report_mismatch($sformatf("green_out %0d, expected %0d",
					got.green_out, want.green_out));
			if (got.blue_out !== want.blue_out)
				report_mismatch($sformatf("blue_out %0d, expected %0d",
					got.blue_out, want.blue_out));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	pixel_in_t in_data;
	logic out_valid;
	logic out_ready;
	pixel_out_t out_data;
	logic cfg_write;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	int unsigned send_idle_pct;
	int unsigned stall_pct;
	filter_scoreboard sb;

	region_gray_sepia_filter dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("region_gray_sepia_filter: mismatch");
		$finish;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_pixel(in_data);
			if (out_valid && out_ready)
				sb.check_pixel(out_data);
		end
	end

	task send_pixel(input pixel_in_t px);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= px;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task wait_for_results();
		in_valid <= 1'b0;
		while (sb.expected_pixels.size() != 0)
			@(negedge clk);
	endtask

	task write_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		sb.write_register(idx, value);
		@(negedge clk);
	endtask

	task program_config(input cfg_t c);
		logic [CFG_W-1:0] word;
		wait_for_results();
		word = CFG_W'($urandom);
		word[0] = c.filter_mode;
		write_register(REG_FILTER_MODE, word);
		write_register(REG_LEFT_COLUMN, c.left_column);
		write_register(REG_TOP_ROW, c.top_row);
		write_register(REG_RIGHT_COLUMN, c.right_column);
		write_register(REG_BOTTOM_ROW, c.bottom_row);
		word = CFG_W'($urandom);
		word[7:0] = c.max_level;
		write_register(REG_MAX_LEVEL, word);
		cfg_write <= 1'b0;
	endtask

	function automatic cfg_t make_config(filter_mode_t mode, coord_t left, coord_t top,
			coord_t right, coord_t bottom, chan_t level);
		cfg_t c;
		c.filter_mode = mode;
		c.left_column = left;
		c.top_row = top;
		c.right_column = right;
		c.bottom_row = bottom;
		c.max_level = level;
		return c;
	endfunction

	function automatic pixel_in_t make_pixel(coord_t row, coord_t col, chan_t r, chan_t g,
			chan_t b);
		pixel_in_t px;
		px.pixel_row = row;
		px.pixel_column = col;
		px.red_in = r;
		px.green_in = g;
		px.blue_in = b;
		return px;
	endfunction

	function automatic coord_t pick_coord(coord_t lo, coord_t hi);
		int unsigned sel;
		sel = $urandom_range(9);
		if (sel < 5 && lo <= hi)
			return coord_t'($urandom_range(hi, lo));
		if (sel < 8) begin
			case ($urandom_range(3))
				0: return lo - 1'b1;
				1: return lo;
				2: return hi;
				default: return hi + 1'b1;
			endcase
		end
		return coord_t'($urandom_range(4095, 0));
	endfunction

	function automatic chan_t pick_level();
		if ($urandom_range(7) == 0)
			return $urandom_range(1) ? 8'hFF : 8'h00;
		return chan_t'($urandom_range(255, 0));
	endfunction

	function automatic pixel_in_t random_pixel(cfg_t c);
		return make_pixel(pick_coord(c.top_row, c.bottom_row),
			pick_coord(c.left_column, c.right_column),
			pick_level(), pick_level(), pick_level());
	endfunction

	function automatic cfg_t phase_settings(int phase);
		cfg_t c;
		coord_t a, b;
		c = make_config(MODE_SEPIA, 12'd0, 12'd0, 12'hFFF, 12'hFFF, 8'hFF);
		case (phase)
			0: c.filter_mode = MODE_GRAY;
			1, 2, 3: begin
				a = coord_t'($urandom_range(4095, 0));
				b = coord_t'($urandom_range(4095, 0));
				c.left_column = (a < b) ? a : b;
				c.right_column = (a < b) ? b : a;
				a = coord_t'($urandom_range(4095, 0));
				b = coord_t'($urandom_range(4095, 0));
				c.top_row = (a < b) ? a : b;
				c.bottom_row = (a < b) ? b : a;
				if (phase == 2)
					c.max_level = chan_t'($urandom_range(255, 1));
				if (phase == 3) begin
					c.filter_mode = MODE_GRAY;
					c.max_level = 8'd1;
				end
			end
			4: begin
				c.left_column = coord_t'($urandom_range(4095, 0));
				c.right_column = c.left_column;
				c.top_row = coord_t'($urandom_range(4095, 0));
				c.bottom_row = c.top_row;
				c.max_level = chan_t'($urandom_range(255, 0));
			end
			5: begin
				a = coord_t'($urandom_range(4095, 1));
				c.left_column = a;
				c.right_column = coord_t'($urandom_range(32'(a) - 32'd1, 0));
				c.max_level = 8'd0;
			end
			6: c.max_level = chan_t'($urandom_range(31, 0));
			default: begin
				c.left_column = coord_t'($urandom_range(4095, 0));
				c.top_row = coord_t'($urandom_range(4095, 0));
			end
		endcase
		return c;
	endfunction

	task run_directed();
		send_pixel(make_pixel(12'd0, 12'd0, 8'd0, 8'd0, 8'd0));
		send_pixel(make_pixel(12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 8'hFF));
		send_pixel(make_pixel(12'hAAA, 12'h555, 8'hAA, 8'h55, 8'h01));
		send_pixel(make_pixel(12'h555, 12'hAAA, 8'd2, 8'd1, 8'd0));

		program_config(make_config(MODE_SEPIA, 12'd100, 12'd10, 12'd200, 12'd20, 8'hFF));
		send_pixel(make_pixel(12'd15, 12'd150, 8'hFF, 8'hFF, 8'hFF));
		send_pixel(make_pixel(12'd15, 12'd150, 8'd100, 8'd50, 8'd20));
		send_pixel(make_pixel(12'd15, 12'd99, 8'd40, 8'd80, 8'd160));
		send_pixel(make_pixel(12'd15, 12'd201, 8'd40, 8'd80, 8'd160));
		send_pixel(make_pixel(12'd10, 12'd100, 8'd40, 8'd80, 8'd160));
		send_pixel(make_pixel(12'd20, 12'd200, 8'd40, 8'd80, 8'd160));
		send_pixel(make_pixel(12'd9, 12'd150, 8'd40, 8'd80, 8'd160));
		send_pixel(make_pixel(12'd21, 12'd150, 8'd40, 8'd80, 8'd160));

		// A zero saturation level forces every sepia channel to black.
		program_config(make_config(MODE_SEPIA, 12'd100, 12'd10, 12'd200, 12'd20, 8'd0));
		send_pixel(make_pixel(12'd15, 12'd150, 8'd200, 8'd100, 8'd50));
		send_pixel(make_pixel(12'd15, 12'd150, 8'd0, 8'd0, 8'd0));

		// The gray average ignores the saturation level.
		program_config(make_config(MODE_GRAY, 12'd100, 12'd10, 12'd200, 12'd20, 8'd5));
		send_pixel(make_pixel(12'd15, 12'd150, 8'hFF, 8'hFF, 8'hFF));
		send_pixel(make_pixel(12'd0, 12'd0, 8'hFF, 8'h80, 8'h7F));

		program_config(make_config(MODE_SEPIA, 12'd300, 12'd0, 12'd299, 12'hFFF, 8'hFF));
		send_pixel(make_pixel(12'd5, 12'd300, 8'd90, 8'd120, 8'd30));
		send_pixel(make_pixel(12'd5, 12'd299, 8'd90, 8'd120, 8'd30));

		program_config(make_config(MODE_SEPIA, 12'd0, 12'd50, 12'hFFF, 12'd49, 8'hFF));
		send_pixel(make_pixel(12'd50, 12'd0, 8'd90, 8'd120, 8'd30));
		send_pixel(make_pixel(12'd49, 12'd7, 8'd90, 8'd120, 8'd30));

		// Writes past the last register must not alias onto the region bounds.
		wait_for_results();
		write_register(REG_UNUSED_LO, 12'h000);
		write_register(REG_UNUSED_HI, 12'hFFF);
		cfg_write <= 1'b0;
		send_pixel(make_pixel(12'd50, 12'd0, 8'd90, 8'd120, 8'd30));
		send_pixel(make_pixel(12'd60, 12'd10, 8'd250, 8'd3, 8'd77));
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		send_idle_pct = 0;
		stall_pct = 0;
		sb = new();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		run_directed();

		for (int phase = 0; phase < 8; phase++) begin
			program_config(phase_settings(phase));
			case (phase % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 60;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 60;
				end
				default: begin
					send_idle_pct = 7;
					stall_pct = 7;
				end
			endcase
			for (int n = 0; n < 150; n++) begin
				if (phase == 2 && n == 75)
					wait_for_results();
				send_pixel(random_pixel(sb.settings));
			end
		end

		in_valid <= 1'b0;
		stall_pct = 0;
		for (int n = 0; n < 5000 && sb.expected_pixels.size() != 0; n++)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (sb.expected_pixels.size() != 0)
			sb.report_mismatch($sformatf("%0d expected beats never arrived",
				sb.expected_pixels.size()));
		if (sb.mismatches == 0)
			$display("region_gray_sepia_filter: match");
		else
			$display("region_gray_sepia_filter: mismatch");
		$finish;
	end

endmodule

/* region_gray_sepia_filter.f */
rtl/rgsf_pkg.sv
rtl/rgsf_front.sv
rtl/rgsf_scale.sv
rtl/rgsf_back.sv
rtl/region_gray_sepia_filter.sv
rtl/rgsf_checker.sv
bench/tb_region_gray_sepia_filter.sv
